// ===== src/iirdf1_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirdf1_pkg
// Shared types and constants for the direct form I filter core.
// ----------------------------------------------------------------------------
package iirdf1_pkg;

	localparam int ORDER_W = 4;
	localparam int OUT_W = 26;
	localparam int STATUS_W = 2;
	localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd4;

	localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_DIV_ZERO = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_SATURATED = 2'd2;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;

	// signed 64 bit accumulation, 64 bit division
	localparam int ACC_W = 64;
	localparam int DIV_W = 64;

	// divider command and response
	typedef struct packed {
		logic start;
		logic signed [DIV_W-1:0] num;
		logic signed [DIV_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic signed [DIV_W-1:0] quo;
	} div_rsp_t;

endpackage

// ===== src/iirdf1_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirdf1_divider
// Radix-2 restoring divider, signed, truncating toward zero, one bit a cycle.
// ----------------------------------------------------------------------------
module iirdf1_divider (
	input  logic                 clk,
	input  logic                 arst_n,
	input  iirdf1_pkg::div_req_t req,
	output iirdf1_pkg::div_rsp_t rsp
);

	localparam int W = iirdf1_pkg::DIV_W;
	localparam int CNT_W = $clog2(W + 1);

	logic busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0] rem_q;
	logic [W-1:0] quo_q;
	logic [W-1:0] den_q;
	logic neg_q;
	logic sat_q;
	logic done_q;

	logic [W:0] trial;
	logic [W-1:0] num_mag;
	logic [W-1:0] den_mag;
	logic [W-1:0] quo_fin;

	assign num_mag = req.num[W-1] ? (~req.num + 1'b1) : req.num;
	assign den_mag = req.den[W-1] ? (~req.den + 1'b1) : req.den;
	assign trial = {rem_q, quo_q[W-1]} - {1'b0, den_q};
	assign quo_fin = neg_q ? (~quo_q + 1'b1) : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= num_mag;
			den_q <= den_mag;
			neg_q <= req.num[W-1] ^ req.den[W-1];
			// most negative over minus one overflows
			sat_q <= (req.num == {1'b1, {(W-1){1'b0}}}) && (req.den == '1);
		end else if (busy_q) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-2:0], quo_q[W-1]};
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo = sat_q ? {1'b0, {(W-1){1'b1}}} : quo_fin;

endmodule

// ===== src/iir_direct_form_one_filter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir_direct_form_one_filter_core
// Direct form I IIR filter with a sequenced multiply and a shared divider.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready) carries load and sample items. A load item
//   writes one b/a pair and gives no result on the out channel. A sample
//   item gives one result on the out channel (out_valid/out_ready).
//   Per sample the sequencer runs order+1 terms; each term passes through a
//   multiply state, a subtract state, a divider start state and a wait
//   state for the 64 step division. out_valid is registered in ST_FIN after
//   the last term; with no stall the next item is taken once out_ready
//   accepts the result and the block is back in idle. A zero a0 answers on
//   the next cycle with status one. in_ready is low while a sample is worked
//   on and while its result waits; a stalled receiver holds the result
//   register and the block waits. The user writes filter_order through
//   cfg_we/cfg_wdata only while idle; the block does not enforce this.
//   Reset clears coefficients and histories and sets the order to four.
// ----------------------------------------------------------------------------
module iir_direct_form_one_filter_core #(
	parameter int MAX_ORDER = 10,
	parameter int SAMPLE_WIDTH = 16,
	parameter int COEF_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [iirdf1_pkg::ORDER_W-1:0]    cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              req_type,
	input  logic [3:0]                        coef_index,
	input  logic signed [COEF_WIDTH-1:0]      coef_forward,
	input  logic signed [COEF_WIDTH-1:0]      coef_feedback,
	input  logic signed [SAMPLE_WIDTH-1:0]    sample_in,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [iirdf1_pkg::OUT_W-1:0] filtered_out,
	output logic [iirdf1_pkg::STATUS_W-1:0]   status
);

	localparam int TAP_W = $clog2(MAX_ORDER + 1);
	localparam int HIST_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
	localparam int ACC_W = iirdf1_pkg::ACC_W;
	localparam int YW = 32;
	localparam int P1W = COEF_WIDTH + SAMPLE_WIDTH;
	localparam int P2W = COEF_WIDTH + YW;
	localparam logic [YW-1:0] RECIP_100 = 32'd2748779070;
	localparam int RECIP_SHIFT = 38;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_MUL  = 7'b0000010,
		ST_SUB  = 7'b0000100,
		ST_DIV  = 7'b0001000,
		ST_WAIT = 7'b0010000,
		ST_FIN  = 7'b0100000,
		ST_OUT  = 7'b1000000
	} state_t;

	state_t state_q;
	logic [iirdf1_pkg::ORDER_W-1:0] order_q;
	logic signed [COEF_WIDTH-1:0] fwd_q [MAX_ORDER+1];
	logic signed [COEF_WIDTH-1:0] fbk_q [MAX_ORDER+1];
	logic signed [SAMPLE_WIDTH-1:0] xh_q [MAX_ORDER];
	logic signed [YW-1:0] yh_q [MAX_ORDER];
	logic [TAP_W-1:0] tap_q;
	logic [TAP_W-1:0] ord_q;
	logic signed [SAMPLE_WIDTH-1:0] x_q;
	logic signed [P1W-1:0] pf_q;
	logic signed [P2W-1:0] pb_q;
	logic signed [ACC_W-1:0] num_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [YW-1:0] y_q;
	logic sat_q;
	logic signed [iirdf1_pkg::OUT_W-1:0] out_q;
	logic [iirdf1_pkg::STATUS_W-1:0] status_q;
	logic out_valid_q;

	iirdf1_pkg::div_req_t dreq;
	iirdf1_pkg::div_rsp_t drsp;

	logic signed [COEF_WIDTH-1:0] b_sel;
	logic signed [COEF_WIDTH-1:0] a_sel;
	logic signed [SAMPLE_WIDTH-1:0] x_sel;
	logic signed [YW-1:0] y_sel;
	logic [TAP_W-1:0] ord_cfg;
	logic signed [ACC_W:0] sum;
	logic signed [ACC_W-1:0] sum_sat;
	logic [YW-1:0] y_mag;
	logic [2*YW-1:0] y_prod;
	logic [YW-1:0] y_quo_mag;
	logic signed [YW-1:0] y_quo;

	assign b_sel = fwd_q[tap_q];
	assign a_sel = fbk_q[tap_q];
	assign x_sel = (tap_q == '0) ? x_q : xh_q[HIST_W'(tap_q - 1'b1)];
	assign y_sel = (tap_q == '0) ? '0 : yh_q[HIST_W'(tap_q - 1'b1)];
	assign ord_cfg = (32'(order_q) > MAX_ORDER) ? TAP_W'(MAX_ORDER) : TAP_W'(order_q);

	assign sum = {drsp.quo[ACC_W-1], drsp.quo} + {acc_q[ACC_W-1], acc_q};
	assign sum_sat = (sum[ACC_W] != sum[ACC_W-1]) ?
		(sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}}) :
		sum[ACC_W-1:0];

	// divide by 100 on the magnitude with ceil(2^38/100), exact for 32 bit values
	assign y_mag = y_q[YW-1] ? (~y_q + 1'b1) : y_q;
	assign y_prod = y_mag * RECIP_100;
	assign y_quo_mag = YW'(y_prod >> RECIP_SHIFT);
	assign y_quo = y_q[YW-1] ? (~y_quo_mag + 1'b1) : y_quo_mag;

	always_comb begin
		dreq.start = (state_q == ST_DIV);
		dreq.num = num_q;
		dreq.den = ACC_W'(fbk_q[0]);
	end

	iirdf1_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign filtered_out = out_q;
	assign status = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			order_q <= iirdf1_pkg::ORDER_RESET;
			out_valid_q <= 1'b0;
			for (int i = 0; i <= MAX_ORDER; i++) begin
				fwd_q[i] <= '0;
				fbk_q[i] <= '0;
			end
			for (int i = 0; i < MAX_ORDER; i++) begin
				xh_q[i] <= '0;
				yh_q[i] <= '0;
			end
		end else begin
			if (cfg_we) order_q <= cfg_wdata;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (req_type == iirdf1_pkg::REQ_LOAD) begin
							if (32'(coef_index) <= MAX_ORDER) begin
								fwd_q[TAP_W'(coef_index)] <= coef_forward;
								fbk_q[TAP_W'(coef_index)] <= coef_feedback;
							end
						end else if (fbk_q[0] == '0) begin
							out_q <= '0;
							status_q <= iirdf1_pkg::STATUS_DIV_ZERO;
							out_valid_q <= 1'b1;
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: state_q <= ST_SUB;
				ST_SUB: state_q <= ST_DIV;
				ST_DIV: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (drsp.done) begin
						if (tap_q == ord_q) state_q <= ST_FIN;
						else state_q <= ST_MUL;
					end
				end
				ST_FIN: begin
					for (int i = 1; i < MAX_ORDER; i++) begin
						if (i < 32'(ord_q)) begin
							xh_q[i] <= xh_q[i-1];
							yh_q[i] <= yh_q[i-1];
						end
					end
					xh_q[0] <= x_q;
					yh_q[0] <= y_q;
					out_q <= iirdf1_pkg::OUT_W'(y_quo);
					status_q <= sat_q ? iirdf1_pkg::STATUS_SATURATED : iirdf1_pkg::STATUS_OK;
					out_valid_q <= 1'b1;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				x_q <= sample_in;
				tap_q <= '0;
				acc_q <= '0;
				ord_q <= ord_cfg;
			end
			ST_MUL: begin
				pf_q <= P1W'(b_sel * x_sel);
				pb_q <= P2W'(a_sel * y_sel);
			end
			ST_SUB: num_q <= ACC_W'(pf_q) - ACC_W'(pb_q);
			ST_WAIT: begin
				if (drsp.done) begin
					acc_q <= sum_sat;
					tap_q <= tap_q + 1'b1;
					if (tap_q == ord_q) begin
						if (sum_sat > 64'sd2147483647) begin
							y_q <= 32'sh7fffffff; sat_q <= 1'b1;
						end else if (sum_sat < -64'sd2147483648) begin
							y_q <= 32'sh80000000; sat_q <= 1'b1;
						end else begin
							y_q <= YW'(sum_sat); sat_q <= 1'b0;
						end
					end
				end
			end
			default: ;
		endcase
	end

endmodule
